### sv/sliding_window_distinct_pressure_top_macros.svh
// assertion macros for the sliding window distinct pressure block
// expects clk and arst_n in the scope of use
`ifndef SLIDING_WINDOW_DISTINCT_PRESSURE_TOP_MACROS_SVH
`define SLIDING_WINDOW_DISTINCT_PRESSURE_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define SWDP_ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// condition implies consequence in the same cycle
`define SWDP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/swdp_pkg.sv
// shared types and constants for the sliding window distinct pressure block
// no dependencies
package swdp_pkg;

	localparam int SLOT_W = 9;
	localparam int SLOT_COUNT = 512;
	localparam int NUM_OPS = 3;
	localparam int CFG_W = 8;
	localparam int BUDGET_W = 8;
	localparam int PEAK_OUT_W = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int MIN_PEAK = 3;
	localparam logic [CFG_W-1:0] DEFAULT_TOTAL = 8'd11;
	localparam logic [CFG_W-1:0] RESET_PARAM = 8'd0;

	typedef logic [SLOT_W-1:0] slot_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_ALLOC_REGS = 1'b0,
		CFG_PARAM_REGS = 1'b1
	} cfg_idx_t;

	// classified item as it sits in the queue
	typedef struct packed {
		logic                 skip;
		logic                 last;
		logic [NUM_OPS-1:0]   op_v;
		slot_t [NUM_OPS-1:0]  op_slot;
	} item_t;

	function automatic logic slot_in_range(slot_t s);
		return 32'(s) < SLOT_COUNT;
	endfunction

endpackage

### sv/swdp_if.sv
// valid/ready channel interfaces for instruction words and budget results
// depends on swdp_pkg
interface swdp_in_if;
	import swdp_pkg::*;
	logic  valid;
	logic  ready;
	logic  skip;
	logic  dest_valid;
	slot_t dest_slot;
	logic  src1_valid;
	slot_t src1_slot;
	logic  src2_valid;
	slot_t src2_slot;
	logic  last_item;

	modport source (
		output valid, skip, dest_valid, dest_slot, src1_valid, src1_slot,
			src2_valid, src2_slot, last_item,
		input  ready
	);
	modport sink (
		input  valid, skip, dest_valid, dest_slot, src1_valid, src1_slot,
			src2_valid, src2_slot, last_item,
		output ready
	);
endinterface

interface swdp_out_if;
	import swdp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [BUDGET_W-1:0]   budget;
	logic [PEAK_OUT_W-1:0] peak_distinct;

	modport source (output valid, budget, peak_distinct, input ready);
	modport sink (input valid, budget, peak_distinct, output ready);
endinterface

### sv/sliding_window_distinct_pressure_top.sv
// top level: configuration registers, front queue and back end
// depends on swdp_pkg, swdp_if, swdp_front, swdp_back and the macros header
//
//   port    dir  payload                                         handshake
//   in_ch   in   skip, dest/src1/src2 valid+slot, last_item      valid/ready
//   out_ch  out  budget, peak_distinct                           valid/ready
//   cfg     in   cfg_index, cfg_data                             cfg_we
//
// one word per cycle sustained while out_ch is not stalled; the new and the replaced row
// are compared combinationally against every other window row
// a result passes the s1 and s2 registers and the output register to reach out_ch
// a stalled result freezes the back end; the 4-entry queue keeps taking words until full
// reset empties the window at once through per-row valid bits; no clearing pass
`include "sliding_window_distinct_pressure_top_macros.svh"

module sliding_window_distinct_pressure_top #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [swdp_pkg::CFG_W-1:0] cfg_data,
	swdp_in_if.sink                    in_ch,
	swdp_out_if.source                 out_ch
);
	import swdp_pkg::*;

	logic [CFG_W-1:0] alloc_regs_q;
	logic [CFG_W-1:0] param_regs_q;
	logic             q_valid;
	logic             q_pop;
	item_t            q_item;
	logic             res_floor_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_regs_q <= DEFAULT_TOTAL;
			param_regs_q <= RESET_PARAM;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ALLOC_REGS: alloc_regs_q <= cfg_data;
				CFG_PARAM_REGS: param_regs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	swdp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.pop     (q_pop),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	swdp_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (q_pop),
		.alloc_regs (alloc_regs_q),
		.param_regs (param_regs_q),
		.out_ch     (out_ch)
	);

	assign res_floor_ok = (out_ch.budget != '0)
		&& (out_ch.peak_distinct >= PEAK_OUT_W'(MIN_PEAK));

	`SWDP_ASSERT_IMPLIES(a_full_queue_nonempty, !in_ch.ready, q_valid, "queue full but empty")
	`SWDP_ASSERT_IMPLIES(a_stall_no_pop, out_ch.valid && !out_ch.ready, !q_pop, "pop during stall")
	`SWDP_ASSERT_IMPLIES(a_result_floor, out_ch.valid, res_floor_ok, "result below floor")

endmodule

### sv/swdp_front.sv
// front end: takes instruction words, marks usable operands, queues them
// depends on swdp_pkg and swdp_in_if
module swdp_front (
	input  logic            clk,
	input  logic            arst_n,
	swdp_in_if.sink         in_ch,
	input  logic            pop,
	output logic            q_valid,
	output swdp_pkg::item_t q_item
);
	import swdp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t            cls;
	item_t            q_mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             push;

	// operand counts only when flagged and inside the slot range
	always_comb begin
		cls.skip       = in_ch.skip;
		cls.last       = in_ch.last_item;
		cls.op_v[0]    = in_ch.dest_valid && slot_in_range(in_ch.dest_slot);
		cls.op_v[1]    = in_ch.src1_valid && slot_in_range(in_ch.src1_slot);
		cls.op_v[2]    = in_ch.src2_valid && slot_in_range(in_ch.src2_slot);
		cls.op_slot[0] = in_ch.dest_slot;
		cls.op_slot[1] = in_ch.src1_slot;
		cls.op_slot[2] = in_ch.src2_slot;
	end

	assign in_ch.ready = (cnt_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign q_item      = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cls;
	end

endmodule

### sv/swdp_back.sv
// back end: operand window, distinct and peak counters, budget result register
// depends on swdp_pkg and swdp_out_if
module swdp_back #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  swdp_pkg::item_t              q_item,
	output logic                         pop,
	input  logic [swdp_pkg::CFG_W-1:0]   alloc_regs,
	input  logic [swdp_pkg::CFG_W-1:0]   param_regs,
	swdp_out_if.source                   out_ch
);
	import swdp_pkg::*;

	localparam int WP_W   = $clog2(WINDOW_DEPTH);
	localparam int PEAK_W = $clog2(NUM_OPS * WINDOW_DEPTH + 1);
	localparam int CNT_W  = $clog2(NUM_OPS + 1);
	localparam int EXT_W  = (PEAK_W > PEAK_OUT_W) ? PEAK_W : PEAK_OUT_W;
	localparam int DIFF_W = ((PEAK_W > CFG_W) ? PEAK_W : CFG_W) + 2;

	logic [NUM_OPS-1:0]   win_v_q    [WINDOW_DEPTH];
	slot_t [NUM_OPS-1:0]  win_slot_q [WINDOW_DEPTH];
	logic [WP_W-1:0]      wp_q;
	logic [WP_W-1:0]      wp_next;

	logic                 advance;
	logic [NUM_OPS-1:0]   hit_new;
	logic [NUM_OPS-1:0]   hit_old;
	logic [NUM_OPS-1:0]   dup_new;
	logic [NUM_OPS-1:0]   dup_old;
	logic [NUM_OPS-1:0]   first_new;
	logic [NUM_OPS-1:0]   last_old;
	logic [CNT_W-1:0]     inc_cnt;
	logic [CNT_W-1:0]     dec_cnt;

	logic                 occ_s1;
	logic                 last_s1;
	logic [CNT_W-1:0]     inc_s1;
	logic [CNT_W-1:0]     dec_s1;

	logic [PEAK_W-1:0]    now_q;
	logic [PEAK_W-1:0]    peak_q;
	logic [PEAK_W-1:0]    now_n;
	logic [PEAK_W-1:0]    peak_n;
	logic                 res_v_s2;
	logic [PEAK_W-1:0]    res_peak_s2;

	logic [PEAK_W-1:0]    peak3;
	logic [EXT_W-1:0]     peak3_ext;
	logic [CFG_W-1:0]     total_eff;
	logic [DIFF_W-1:0]    diff;
	logic [BUDGET_W-1:0]  budget_n;
	logic [PEAK_OUT_W-1:0] peak_out_n;

	logic                  out_valid_q;
	logic [BUDGET_W-1:0]   budget_q;
	logic [PEAK_OUT_W-1:0] peak_out_q;

	// whole back end moves together; the output register is its last stage
	assign advance = !out_valid_q || out_ch.ready;
	assign pop     = advance && q_valid;

	assign wp_next = (wp_q == WP_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + WP_W'(1);

	// row wp_q is the one replaced; all other rows stay in the window
	always_comb begin
		hit_new = '0;
		hit_old = '0;
		for (int r = 0; r < WINDOW_DEPTH; r++) begin
			if (WP_W'(r) != wp_q) begin
				for (int k = 0; k < NUM_OPS; k++) begin
					for (int j = 0; j < NUM_OPS; j++) begin
						if (win_v_q[r][k] && win_slot_q[r][k] == q_item.op_slot[j])
							hit_new[j] = 1'b1;
						if (win_v_q[r][k] && win_slot_q[r][k] == win_slot_q[wp_q][j])
							hit_old[j] = 1'b1;
					end
				end
			end
		end
	end

	// same slot twice in one row counts once
	always_comb begin
		dup_new = '0;
		dup_old = '0;
		for (int j = 0; j < NUM_OPS; j++) begin
			for (int k = 0; k < j; k++) begin
				if (q_item.op_v[k] && q_item.op_slot[k] == q_item.op_slot[j])
					dup_new[j] = 1'b1;
				if (win_v_q[wp_q][k] && win_slot_q[wp_q][k] == win_slot_q[wp_q][j])
					dup_old[j] = 1'b1;
			end
		end
		inc_cnt = '0;
		dec_cnt = '0;
		for (int j = 0; j < NUM_OPS; j++) begin
			first_new[j] = q_item.op_v[j] && !hit_new[j] && !dup_new[j];
			last_old[j]  = win_v_q[wp_q][j] && !hit_old[j] && !dup_old[j];
			inc_cnt      = inc_cnt + CNT_W'(first_new[j]);
			dec_cnt      = dec_cnt + CNT_W'(last_old[j]);
		end
	end

	assign now_n  = now_q + PEAK_W'(inc_s1) - PEAK_W'(dec_s1);
	assign peak_n = (now_n > peak_q) ? now_n : peak_q;

	// budget from the captured peak
	always_comb begin
		peak3      = (res_peak_s2 < PEAK_W'(MIN_PEAK)) ? PEAK_W'(MIN_PEAK) : res_peak_s2;
		peak3_ext  = EXT_W'(peak3);
		total_eff  = (alloc_regs == '0) ? DEFAULT_TOTAL : alloc_regs;
		diff       = DIFF_W'(total_eff) - DIFF_W'(param_regs) - DIFF_W'(peak3);
		budget_n   = (diff[DIFF_W-1] || diff == '0) ? BUDGET_W'(1) : diff[BUDGET_W-1:0];
		peak_out_n = (peak3_ext > EXT_W'({PEAK_OUT_W{1'b1}})) ? {PEAK_OUT_W{1'b1}}
			: peak3_ext[PEAK_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < WINDOW_DEPTH; r++)
				win_v_q[r] <= '0;
			wp_q        <= '0;
			occ_s1      <= 1'b0;
			last_s1     <= 1'b0;
			inc_s1      <= '0;
			dec_s1      <= '0;
			now_q       <= '0;
			peak_q      <= '0;
			res_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			// window update
			if (q_valid) begin
				if (q_item.last) begin
					for (int r = 0; r < WINDOW_DEPTH; r++)
						win_v_q[r] <= '0;
					wp_q <= '0;
				end else if (!q_item.skip) begin
					win_v_q[wp_q] <= q_item.op_v;
					wp_q          <= wp_next;
				end
			end
			occ_s1  <= q_valid;
			last_s1 <= q_valid && q_item.last;
			inc_s1  <= (q_valid && !q_item.skip) ? inc_cnt : '0;
			dec_s1  <= (q_valid && !q_item.skip) ? dec_cnt : '0;
			// counters
			res_v_s2 <= occ_s1 && last_s1;
			if (occ_s1) begin
				if (last_s1) begin
					now_q  <= '0;
					peak_q <= '0;
				end else begin
					now_q  <= now_n;
					peak_q <= peak_n;
				end
			end
			out_valid_q <= res_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !q_item.skip)
			win_slot_q[wp_q] <= q_item.op_slot;
		if (advance && occ_s1 && last_s1)
			res_peak_s2 <= peak_n;
		if (advance && res_v_s2) begin
			budget_q   <= budget_n;
			peak_out_q <= peak_out_n;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.budget        = budget_q;
	assign out_ch.peak_distinct = peak_out_q;

endmodule
